/* hdl/stfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfa_pkg
// Shared constants and controller/datapath interface types for the strided
// temporal frame average.
// ----------------------------------------------------------------------------
package stfa_pkg;

    localparam int MAX_FRAMES_DEF       = 16;
    localparam int MAX_FRAME_PIXELS_DEF = 65536;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_FRAMES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_STRIDE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PIXELS   = 2'd2;

    localparam logic [4:0]  HISTORY_FRAMES_RST = 5'd16;
    localparam logic [4:0]  FRAME_STRIDE_RST   = 5'd4;
    localparam logic [16:0] FRAME_PIXELS_RST   = 17'd65536;

    typedef struct packed {
        logic accept;
        logic write;
        logic read;
        logic accum;
        logic div_start;
        logic div_step;
        logic load_out;
    } stfa_cmd_t;

    typedef struct packed {
        logic more_frames;
        logic out_busy;
    } stfa_status_t;

endpackage

/* hdl/stfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfa_ctrl
// Sequencer that steps one pixel through store write, history reads,
// accumulation, serial division and output load.
// ----------------------------------------------------------------------------
module stfa_ctrl #(
    parameter int DIV_STEPS = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output stfa_pkg::stfa_cmd_t    cmd,
    input  stfa_pkg::stfa_status_t status
);
    import stfa_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_READ  = 6'b000100,
        S_ACC   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum = 1'b1;
                if (status.more_frames)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = CW'(DIV_STEPS);
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/stfa_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfa_datapath
// Configuration registers, frame bookkeeping, history memory, channel
// accumulators, serial dividers and the output register.
// ----------------------------------------------------------------------------
module stfa_datapath #(
    parameter int MAX_FRAMES       = stfa_pkg::MAX_FRAMES_DEF,
    parameter int MAX_FRAME_PIXELS = stfa_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [stfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [31:0]                    s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,
    input  stfa_pkg::stfa_cmd_t             cmd,
    output stfa_pkg::stfa_status_t          status
);
    import stfa_pkg::*;

    localparam int FW    = $clog2(MAX_FRAMES + 1);
    localparam int SW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PW    = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int DEPTH = MAX_FRAMES * MAX_FRAME_PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = 8 + FW;

    logic [4:0]  hf_cfg_reg;
    logic [4:0]  st_cfg_reg;
    logic [16:0] fp_cfg_reg;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] cur_pos_reg;
    logic [SW-1:0] newest_reg;
    logic [FW-1:0] held_reg;
    logic [31:0]   pix_reg;
    logic [FW-1:0] off_reg;
    logic [SW-1:0] rd_slot_reg;
    logic [FW-1:0] n_reg;
    logic [31:0]   rdata_reg;
    logic [SUM_W-1:0] sum_reg [4];
    logic [FW-1:0]    rem_reg [4];
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;

    logic [31:0] mem [DEPTH];

    logic [FW-1:0] hf_eff;
    logic [4:0]    st_eff;
    logic [7:0]    hf_wide;
    logic [PW-1:0] p0;
    logic [FW-1:0] h0;
    logic [FW:0]   h_inc;
    logic [23:0]   p_inc;
    logic [23:0]   fp_eff;
    logic [7:0]    off_sum;
    logic [7:0]    slot_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        hf_wide = {3'b000, hf_cfg_reg};
        if (hf_wide == 8'd0)
        begin
            hf_eff = FW'(1);
        end
        else if (hf_wide > 8'(MAX_FRAMES))
        begin
            hf_eff = FW'(MAX_FRAMES);
        end
        else
        begin
            hf_eff = FW'(hf_wide);
        end
        st_eff   = (st_cfg_reg == 5'd0) ? 5'd1 : st_cfg_reg;
        fp_eff   = (fp_cfg_reg == 17'd0) ? 24'd1 : {7'd0, fp_cfg_reg};
        p0       = s_tuser ? '0 : pos_reg;
        h0       = s_tuser ? '0 : held_reg;
        h_inc    = {1'b0, h0} + 1'b1;
        p_inc    = 24'(p0) + 24'd1;
        off_sum  = 8'(off_reg) + {3'b000, st_eff};
        slot_sum = (8'(rd_slot_reg) >= {3'b000, st_eff})
                 ? 8'(rd_slot_reg) - {3'b000, st_eff}
                 : 8'(rd_slot_reg) + 8'(MAX_FRAMES) - {3'b000, st_eff};
        wr_addr  = AW'(newest_reg) * AW'(MAX_FRAME_PIXELS) + AW'(cur_pos_reg);
        rd_addr  = AW'(rd_slot_reg) * AW'(MAX_FRAME_PIXELS) + AW'(cur_pos_reg);
    end

    assign status.more_frames = (off_sum < 8'(held_reg));
    assign status.out_busy    = out_valid_reg && !m_tready;
    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_cfg_reg    <= HISTORY_FRAMES_RST;
            st_cfg_reg    <= FRAME_STRIDE_RST;
            fp_cfg_reg    <= FRAME_PIXELS_RST;
            pos_reg       <= '0;
            newest_reg    <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HISTORY_FRAMES: hf_cfg_reg <= cfg_data[4:0];
                    CFG_FRAME_STRIDE:   st_cfg_reg <= cfg_data[4:0];
                    CFG_FRAME_PIXELS:   fp_cfg_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.accept)
            begin
                if (p0 == '0)
                begin
                    newest_reg <= (newest_reg == SW'(MAX_FRAMES - 1)) ? '0 : newest_reg + 1'b1;
                    held_reg   <= (h_inc > {1'b0, hf_eff}) ? hf_eff : h_inc[FW-1:0];
                end
                else
                begin
                    held_reg <= h0;
                end
                if (p_inc >= fp_eff || p_inc >= 24'(MAX_FRAME_PIXELS))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= p_inc[PW-1:0];
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_addr] <= pix_reg;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [FW:0] trial;
        if (cmd.accept)
        begin
            pix_reg     <= s_tdata;
            cur_pos_reg <= p0;
        end
        if (cmd.write)
        begin
            off_reg     <= '0;
            rd_slot_reg <= newest_reg;
            n_reg       <= '0;
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        if (cmd.accum)
        begin
            off_reg     <= off_sum[FW-1:0];
            rd_slot_reg <= slot_sum[SW-1:0];
            n_reg       <= n_reg + 1'b1;
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(rdata_reg[8*c +: 8]);
            end
        end
        if (cmd.div_start)
        begin
            for (int c = 0; c < 4; c++)
            begin
                rem_reg[c] <= '0;
            end
        end
        if (cmd.div_step)
        begin
            for (int c = 0; c < 4; c++)
            begin
                trial = {rem_reg[c], sum_reg[c][SUM_W-1]};
                if (trial >= {1'b0, n_reg})
                begin
                    rem_reg[c] <= FW'(trial - {1'b0, n_reg});
                    sum_reg[c] <= {sum_reg[c][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= trial[FW-1:0];
                    sum_reg[c] <= {sum_reg[c][SUM_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {sum_reg[3][7:0], sum_reg[2][7:0],
                             sum_reg[1][7:0], sum_reg[0][7:0]};
        end
    end

endmodule

/* hdl/strided_temporal_frame_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_temporal_frame_average
// Averages each RGBA pixel over strided frames of a ring of stored frames.
// A result word is loaded after its pixel is taken, through one store write,
// a read and add per frame averaged on the single memory port, serial division
// of the channel sums, and one load. A pixel is taken only after the previous
// result is loaded; the next pixel is taken while a finished result waits on
// the output.
// Reset clears control and returns the configuration to its defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
module strided_temporal_frame_average #(
    parameter int MAX_FRAMES       = stfa_pkg::MAX_FRAMES_DEF,
    parameter int MAX_FRAME_PIXELS = stfa_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  logic                           s_tuser,   // new_format
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata    // red_out, green_out, blue_out, alpha_out
);
    import stfa_pkg::*;

    localparam int SUM_W = 8 + $clog2(MAX_FRAMES + 1);

    stfa_cmd_t    cmd;
    stfa_status_t status;

    assign cfg_ready = 1'b1;

    stfa_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stfa_datapath #(
        .MAX_FRAMES       (MAX_FRAMES),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
